@@ src/ils_pkg.sv @@
package ils_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W + 1 > 8) ? CNT_W + 1 : 8;

	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int LEN_W    = 7;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;
	localparam int USER_W   = 2;

	typedef enum logic [1:0] {
		REQ_READ   = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic [DATA_W-1:0] NO_VALUE = '1;

	typedef struct packed {
		logic load_new;
		logic load_prev;
		logic load_next;
		logic rd_sel;
	} cell_ctl_t;

endpackage

@@ src/ils_cell.sv @@
module ils_cell (
	input  logic                      clk,
	input  ils_pkg::cell_ctl_t        ctl,
	input  logic [ils_pkg::DATA_W-1:0] new_value,
	input  logic [ils_pkg::DATA_W-1:0] prev_value,
	input  logic [ils_pkg::DATA_W-1:0] next_value,
	output logic [ils_pkg::DATA_W-1:0] value,
	output logic [ils_pkg::DATA_W-1:0] rd_term
);
	import ils_pkg::*;

	logic [DATA_W-1:0] value_q;

	// One entry of the list; shifts toward either neighbor on insert or delete.
	always_ff @(posedge clk) begin
		if (ctl.load_new) begin
			value_q <= new_value;
		end else if (ctl.load_prev) begin
			value_q <= prev_value;
		end else if (ctl.load_next) begin
			value_q <= next_value;
		end
	end

	assign value   = value_q;
	assign rd_term = value_q & {DATA_W{ctl.rd_sel}};

endmodule

@@ src/indexed_list_store.sv @@
// Channel | Dir | Beat contents (lowest bit first)
// s_*     | in  | tdata: position[7:0], item_value[39:8]; tuser: req_type[1:0]
// m_*     | out | tdata: read_value[31:0], length[38:32], zero[39]; tuser: status[1:0]
//
// On each request the row of cells shifts, loads or is read in the cycle the beat
// is accepted, and the result sits in the output register next cycle.
// A new beat is accepted every cycle while the output register is empty or drained.
// The length counter clears on reset; entry contents are not cleared.
// A stalled result holds s_tready low until it is taken.
module indexed_list_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ils_pkg::S_DATA_W-1:0]  s_tdata,  // position, item_value
	input  logic [ils_pkg::USER_W-1:0]    s_tuser,  // req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ils_pkg::M_DATA_W-1:0]  m_tdata,  // read_value, length
	output logic [ils_pkg::USER_W-1:0]    m_tuser   // status
);
	import ils_pkg::*;

	logic signed [POS_W-1:0]  position;
	logic [DATA_W-1:0]        item_value;
	logic [USER_W-1:0]        req_type;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     m_valid_q;
	logic [DATA_W-1:0]        read_value_q;
	logic [LEN_W-1:0]         length_q;
	logic [USER_W-1:0]        status_q;

	logic                     accept;
	logic signed [CMP_W-1:0]  pos_s;
	logic signed [CMP_W-1:0]  cnt_s;
	logic                     pos_in_list;
	logic                     ins_pos_ok;
	logic                     full;
	logic                     rd_go;
	logic                     ins_go;
	logic                     del_go;
	logic [IDX_W-1:0]         ins_idx;
	logic [IDX_W-1:0]         acc_idx;
	logic [DATA_W-1:0]        rd_data;
	logic [DATA_W-1:0]        read_value_d;
	status_t                  status_d;

	cell_ctl_t                ctl   [CAPACITY];
	logic [DATA_W-1:0]        value [CAPACITY];
	logic [DATA_W-1:0]        term  [CAPACITY];

	assign position   = s_tdata[POS_W-1:0];
	assign item_value = s_tdata[POS_W+DATA_W-1:POS_W];
	assign req_type   = s_tuser;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos_s = CMP_W'(position);
	assign cnt_s = signed'(CMP_W'(count_q));

	assign pos_in_list = !position[POS_W-1] && (pos_s < cnt_s);
	assign ins_pos_ok  = pos_s <= cnt_s;
	assign full        = count_q == CNT_W'(CAPACITY);

	assign rd_go  = accept && (req_type == REQ_READ) && pos_in_list;
	assign ins_go = accept && (req_type == REQ_INSERT) && ins_pos_ok && !full;
	assign del_go = accept && (req_type == REQ_DELETE) && pos_in_list;

	// Inside the list the position fits the cell index; a negative insert clamps to 0.
	assign acc_idx = position[IDX_W-1:0];
	assign ins_idx = position[POS_W-1] ? '0 : acc_idx;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign ctl[i].load_new  = ins_go && (IDX_W'(i) == ins_idx);
		assign ctl[i].load_prev = ins_go && (IDX_W'(i) >  ins_idx);
		assign ctl[i].load_next = del_go && (IDX_W'(i) >= acc_idx);
		assign ctl[i].rd_sel    = rd_go  && (IDX_W'(i) == acc_idx);

		ils_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.new_value  (item_value),
			.prev_value ((i == 0) ? item_value : value[(i == 0) ? 0 : i - 1]),
			.next_value ((i == CAPACITY - 1) ? value[i] :
			             value[(i == CAPACITY - 1) ? i : i + 1]),
			.value      (value[i]),
			.rd_term    (term[i])
		);
	end

	// Only the selected cell drives a nonzero term.
	always_comb begin
		rd_data = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_data = rd_data | term[k];
		end
	end

	always_comb begin
		read_value_d = NO_VALUE;
		status_d     = ST_RANGE;
		count_d      = count_q;
		case (req_type_t'(req_type))
			REQ_READ: begin
				if (pos_in_list) begin
					read_value_d = rd_data;
					status_d     = ST_DONE;
				end
			end
			REQ_INSERT: begin
				if (ins_pos_ok) begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						status_d = ST_DONE;
						count_d  = count_q + CNT_W'(1);
					end
				end
			end
			REQ_DELETE: begin
				if (pos_in_list) begin
					status_d = ST_DONE;
					count_d  = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_value_d;
			status_q     <= status_d;
			length_q     <= LEN_W'(count_d);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W - DATA_W - LEN_W){1'b0}}, length_q, read_value_q};
	assign m_tuser  = status_q;

endmodule

@@ src/ils_checker.sv @@
module ils_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [ils_pkg::S_DATA_W-1:0] s_tdata,
	input logic [ils_pkg::USER_W-1:0]   s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ils_pkg::M_DATA_W-1:0] m_tdata,
	input logic [ils_pkg::USER_W-1:0]   m_tuser
);
	import ils_pkg::*;

	logic [DATA_W-1:0] out_value;
	logic [LEN_W-1:0]  out_length;
	logic              in_beat;

	assign out_value  = m_tdata[DATA_W-1:0];
	assign out_length = m_tdata[DATA_W+LEN_W-1:DATA_W];
	assign in_beat    = s_tvalid && (s_tdata != '0 || s_tuser != '0 || 1'b1);

	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// The input side opens exactly when the output register can take a result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output register occupancy");

	// Every ignored request reports no value.
	a_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_RANGE || m_tuser == ST_FULL) |-> out_value == NO_VALUE)
		else $error("read_value not all ones on an ignored request");

	// A full report only comes with a full list.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> out_length == LEN_W'(CAPACITY))
		else $error("list full reported below capacity");

	// An accepted beat always yields a result next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && s_tready |=> m_tvalid)
		else $error("accepted beat produced no result");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

@@ sim/list_result_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the list store, keeps its own copy of the list and
// compares every result beat with the oldest predicted one.
module list_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [ils_pkg::S_DATA_W-1:0]  s_tdata,  // position, item_value
	input  logic [ils_pkg::USER_W-1:0]    s_tuser,  // req_type
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [ils_pkg::M_DATA_W-1:0]  m_tdata,  // read_value, length
	input  logic [ils_pkg::USER_W-1:0]    m_tuser,  // status
	output int                            fail_count,
	output int                            pending,
	output logic [ils_pkg::LEN_W-1:0]     list_length
);
	import ils_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		status_t           status;
		logic [LEN_W-1:0]  length;
	} list_result_t;

	logic [DATA_W-1:0] shadow_entries [CAPACITY];
	int                shadow_count = 0;
	list_result_t      expected_q [$];
	int                errors = 0;

	assign fail_count = errors;

	// Applies one request to the shadow list and returns the result it should give.
	function automatic list_result_t apply_request(logic [1:0] op,
			logic signed [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		list_result_t res;
		int           p;
		int           i;
		res.read_value = NO_VALUE;
		res.status     = ST_RANGE;
		p              = int'(pos);
		case (op)
			REQ_READ: begin
				if (p >= 0 && p < shadow_count) begin
					res.read_value = shadow_entries[p];
					res.status     = ST_DONE;
				end
			end
			REQ_INSERT: begin
				// The position is checked before the list is found full.
				if (p <= shadow_count) begin
					if (p < 0)
						p = 0;
					if (shadow_count >= CAPACITY) begin
						res.status = ST_FULL;
					end else begin
						for (i = shadow_count; i > p; i--)
							shadow_entries[i] = shadow_entries[i-1];
						shadow_entries[p] = val;
						shadow_count++;
						res.status = ST_DONE;
					end
				end
			end
			REQ_DELETE: begin
				if (p >= 0 && p < shadow_count) begin
					for (i = p; i < shadow_count - 1; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
					res.status = ST_DONE;
				end
			end
			default: ;
		endcase
		res.length = shadow_count[LEN_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t exp_res;
		list_result_t got_res;
		if (!arst_n) begin
			shadow_count = 0;
			expected_q.delete();
			pending     <= 0;
			list_length <= '0;
		end else begin
			// A result never leaves in the same cycle as its request, so check first.
			if (m_tvalid && m_tready) begin
				got_res.read_value = m_tdata[DATA_W-1:0];
				got_res.length     = m_tdata[DATA_W+LEN_W-1:DATA_W];
				got_res.status     = status_t'(m_tuser);
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result beat: expected none, got %h",
						$time, got_res);
				end else begin
					exp_res = expected_q.pop_front();
					if (got_res.read_value !== exp_res.read_value) begin
						errors++;
						$display("%0t read_value: expected %h, got %h",
							$time, exp_res.read_value, got_res.read_value);
					end
					if (got_res.status !== exp_res.status) begin
						errors++;
						$display("%0t status: expected %0d, got %0d",
							$time, exp_res.status, got_res.status);
					end
					if (got_res.length !== exp_res.length) begin
						errors++;
						$display("%0t length: expected %0d, got %0d",
							$time, exp_res.length, got_res.length);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(apply_request(s_tuser, s_tdata[POS_W-1:0],
					s_tdata[POS_W+DATA_W-1:POS_W]));
			pending     <= expected_q.size();
			list_length <= shadow_count[LEN_W-1:0];
		end
	end

endmodule

@@ sim/tb_indexed_list_store.sv @@
`timescale 1ns / 100ps

module tb_indexed_list_store;
	import ils_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int RANDOM_PER_PHASE = 160;
	localparam int BLOCK_LEN        = 90;
	localparam int STALL_LIMIT      = 5000;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;  // position[7:0], item_value[39:8]
	logic [USER_W-1:0]   s_tuser  = '0;  // req_type[1:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // read_value[31:0], length[38:32], zero[39]
	logic [USER_W-1:0]   m_tuser;        // status[1:0]

	int                  fail_count;
	int                  pending;
	logic [LEN_W-1:0]    list_length;
	int                  tx_idle_pct = 0;
	int                  rx_idle_pct = 0;
	int                  quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	indexed_list_store u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	list_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.list_length (list_length)
	);

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	// Ends the run if no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, pos};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// The count of outstanding results is registered, so stop sending and let it update first.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	// Blocks of requests alternate between growing the list until it fills,
	// a balanced mix, and draining it, with some malformed requests throughout.
	task automatic random_request(input int idx);
		logic [1:0]       op;
		logic [POS_W-1:0] pos;
		int               len;
		int               r;
		int               mode;
		len  = int'(list_length);
		mode = (idx / BLOCK_LEN) % 3;
		r    = $urandom_range(99);
		if ($urandom_range(99) < 12) begin
			op  = 2'($urandom_range(3));
			pos = POS_W'($urandom_range(255));
		end else begin
			case (mode)
				0:       op = (r < 85) ? REQ_INSERT : (r < 95) ? REQ_READ : REQ_DELETE;
				1:       op = (r < 35) ? REQ_INSERT : (r < 70) ? REQ_READ : REQ_DELETE;
				default: op = (r < 80) ? REQ_DELETE : (r < 95) ? REQ_READ : REQ_INSERT;
			endcase
			if (op == REQ_INSERT)
				pos = ($urandom_range(19) == 0) ? POS_W'(-$urandom_range(1, 128))
					: POS_W'($urandom_range(len));
			else
				pos = (len == 0) ? '0 : POS_W'($urandom_range(len - 1));
		end
		send_request(op, pos, pick_value());
	endtask

	initial begin
		int idx;
		idx = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 15;
		rx_idle_pct = 58;
		// Empty list, clamped and out-of-range positions, head, middle and tail.
		send_request(REQ_READ,    0,    $urandom);
		send_request(REQ_DELETE,  0,    $urandom);
		send_request(REQ_INSERT,  1,    $urandom);
		send_request(REQ_INSERT,  -128, 32'h8000_0000);
		send_request(REQ_INSERT,  1,    32'h7FFF_FFFF);
		send_request(REQ_INSERT,  0,    '1);
		send_request(REQ_INSERT,  1,    '0);
		send_request(REQ_READ,    0,    $urandom);
		send_request(REQ_READ,    1,    $urandom);
		send_request(REQ_READ,    2,    $urandom);
		send_request(REQ_READ,    3,    $urandom);
		send_request(REQ_READ,    4,    $urandom);
		send_request(REQ_READ,    -1,   $urandom);
		send_request(REQ_READ,    127,  $urandom);
		send_request(REQ_UNKNOWN, 0,    $urandom);
		send_request(REQ_DELETE,  1,    $urandom);
		send_request(REQ_DELETE,  -1,   $urandom);
		send_request(REQ_DELETE,  3,    $urandom);
		send_request(REQ_DELETE,  2,    $urandom);
		send_request(REQ_READ,    1,    $urandom);
		send_request(REQ_INSERT,  2,    $urandom);
		send_request(REQ_INSERT,  5,    $urandom);
		wait_drained();

		repeat (RANDOM_PER_PHASE) begin
			random_request(idx);
			idx++;
		end
		wait_drained();

		tx_idle_pct = 58;
		rx_idle_pct = 15;
		repeat (RANDOM_PER_PHASE) begin
			random_request(idx);
			idx++;
		end
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (RANDOM_PER_PHASE) begin
			random_request(idx);
			idx++;
		end
		wait_drained();
		repeat (10) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
